// File: rtl/gbnr_pkg.sv
// ----------------------------------------------------------------------------
// gbnr_pkg: shared types and constants for the go-back-N frame receiver
// Field widths, sequence constants, character codes, verdict codes, records, CRC step.
// ----------------------------------------------------------------------------
package gbnr_pkg;

  // Field widths
  localparam int SEQ_W     = 14;
  localparam int CRC_W     = 16;
  localparam int HCRC_W    = 17;
  localparam int BYTE_W    = 8;
  localparam int VERDICT_W = 3;

  // Sequence numbering
  localparam logic [SEQ_W-1:0] SEQ_MAX         = SEQ_W'(9999);
  localparam logic [SEQ_W-1:0] START_SEQ_RESET = SEQ_W'(1000);

  // Default frame size limit
  localparam int DEFAULT_MAX_FRAME_BYTES = 256;

  // CRC-16/XMODEM polynomial
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_0    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9    = 8'h39;
  localparam logic [BYTE_W-1:0] CHAR_DATA = 8'h4D;  // 'M'
  localparam logic [BYTE_W-1:0] CHAR_ACK  = 8'h41;  // 'A'

  // Verdict codes
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_DELIVER    = 3'd0,
    VERDICT_DUPLICATE  = 3'd1,
    VERDICT_OUT_OF_ORD = 3'd2,
    VERDICT_BAD_CRC    = 3'd3,
    VERDICT_BAD_HEADER = 3'd4,
    VERDICT_ACK        = 3'd5
  } verdict_t;

  // One received byte as held in the input register
  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_end;
  } byte_item_t;

  // One frame verdict record
  typedef struct packed {
    verdict_t           verdict;
    logic [SEQ_W-1:0]   frame_sequence;
    logic               send_ack;
    logic               deliver_payload;
    logic [SEQ_W-1:0]   next_expected;
    logic [CRC_W-1:0]   computed_crc;
    logic [HCRC_W-1:0]  header_crc;
  } result_t;

  // Bitwise CRC-16/XMODEM update over one byte, MSB first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0]  c;
    logic [BYTE_W-1:0] x;
    c = crc_in;
    x = data;
    for (int k = 0; k < BYTE_W; k++) begin
      if (x[BYTE_W-1] ^ c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
      x = {x[BYTE_W-2:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: rtl/gbnr_ifs.sv
// ----------------------------------------------------------------------------
// gbnr_ifs: valid/ready channels of the go-back-N frame receiver
// Byte input channel, verdict output channel and configuration write channel.
// ----------------------------------------------------------------------------

// Received frame bytes
interface gbnr_byte_if;
  logic                        valid;
  logic                        ready;
  logic [gbnr_pkg::BYTE_W-1:0] rx_byte;
  logic                        frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// Frame verdicts
interface gbnr_result_if;
  logic                        valid;
  logic                        ready;
  gbnr_pkg::verdict_t          verdict;
  logic [gbnr_pkg::SEQ_W-1:0]  frame_sequence;
  logic                        send_ack;
  logic                        deliver_payload;
  logic [gbnr_pkg::SEQ_W-1:0]  next_expected;
  logic [gbnr_pkg::CRC_W-1:0]  computed_crc;
  logic [gbnr_pkg::HCRC_W-1:0] header_crc;

  modport source (output valid, output verdict, output frame_sequence, output send_ack,
                  output deliver_payload, output next_expected, output computed_crc,
                  output header_crc, input ready);
  modport sink   (input valid, input verdict, input frame_sequence, input send_ack,
                  input deliver_payload, input next_expected, input computed_crc,
                  input header_crc, output ready);
endinterface

// Start sequence register writes
interface gbnr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [gbnr_pkg::SEQ_W-1:0] start_sequence;

  modport source (output valid, output start_sequence, input ready);
  modport sink   (input valid, input start_sequence, output ready);
endinterface

// File: rtl/go_back_n_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// go_back_n_frame_receiver_core: go-back-N frame receiver
// Parses frame headers, checks CRC-16/XMODEM and tracks the expected sequence.
// ----------------------------------------------------------------------------
// Usage:
//   rx  : one frame byte per transaction, frame_end set on the last byte.
//   res : one verdict transaction per frame, issued for the byte with
//         frame_end; other bytes produce nothing on this channel.
//   cfg : writes start_sequence (saturated to 9999); it also becomes the
//         expected sequence and the frame in progress is discarded. Write only
//         while no frame is in progress and no verdict is pending.
// Throughput: one byte per cycle unless a frame end waits on a held verdict. The
//   whole per-byte update (header digits, one-byte CRC step, verdict compare) sits
//   between the input register and the frame state / verdict register.
// Verdict path: the last byte passes the input register and then the verdict
//   register before its verdict appears on res; a held verdict can stall it.
// Reset: expected sequence 1000, no frame in progress, both registers empty.
// Stall: while a verdict waits on res, payload bytes keep flowing; a further
//   frame end waits in the input register and rx.ready drops behind it.
// ----------------------------------------------------------------------------
module go_back_n_frame_receiver_core #(
  parameter int MAX_FRAME_BYTES = gbnr_pkg::DEFAULT_MAX_FRAME_BYTES
) (
  input  logic          clk,
  input  logic          rst,
  gbnr_byte_if.sink     rx,
  gbnr_result_if.source res,
  gbnr_cfg_if.sink      cfg
);

  logic                 item_valid;
  gbnr_pkg::byte_item_t item;
  logic                 item_take;
  logic                 out_free;
  gbnr_pkg::result_t    result;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  // A frame end moves on only when the output register has room
  assign item_take = item_valid && (!item.frame_end || out_free);

  gbnr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  gbnr_frame #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_frame (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_value (cfg.start_sequence),
    .step      (item_take),
    .item      (item),
    .result    (result)
  );

  gbnr_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (item_take && item.frame_end),
    .result   (result),
    .out_free (out_free),
    .res      (res)
  );

endmodule

// File: rtl/gbnr_in_reg.sv
// ----------------------------------------------------------------------------
// gbnr_in_reg: input register
// Holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
module gbnr_in_reg (
  input  logic                 clk,
  input  logic                 rst,
  gbnr_byte_if.sink            rx,
  output logic                 item_valid,
  output gbnr_pkg::byte_item_t item,
  input  logic                 item_take
);

  // Refill whenever empty or being drained this cycle
  assign rx.ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (rx.ready) begin
      item_valid <= rx.valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      item.rx_byte   <= rx.rx_byte;
      item.frame_end <= rx.frame_end;
    end
  end

endmodule

// File: rtl/gbnr_frame.sv
// ----------------------------------------------------------------------------
// gbnr_frame: frame parser, CRC and sequence tracking
// Updates the per-frame state for one byte per cycle while bytes are taken, and forms the verdict.
// ----------------------------------------------------------------------------
module gbnr_frame #(
  parameter int MAX_FRAME_BYTES = gbnr_pkg::DEFAULT_MAX_FRAME_BYTES
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [gbnr_pkg::SEQ_W-1:0] cfg_value,
  input  logic                       step,
  input  gbnr_pkg::byte_item_t       item,
  output gbnr_pkg::result_t          result
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_TYPE  = POS_W'(4);
  localparam logic [POS_W-1:0] POS_DATA  = POS_W'(10);
  localparam logic [POS_W-1:0] POS_ACKOK = POS_W'(5);

  // Frame state
  logic [POS_W-1:0]            pos;
  logic [gbnr_pkg::SEQ_W-1:0]  seq_acc;
  logic [gbnr_pkg::BYTE_W-1:0] ftype;
  logic [gbnr_pkg::HCRC_W-1:0] crc_acc;
  logic [gbnr_pkg::CRC_W-1:0]  crc;
  logic                        zero_seen;
  logic                        digits_ok;
  logic [gbnr_pkg::SEQ_W-1:0]  expected;

  logic [POS_W-1:0]            pos_next;
  logic [gbnr_pkg::SEQ_W-1:0]  seq_acc_next;
  logic [gbnr_pkg::BYTE_W-1:0] ftype_next;
  logic [gbnr_pkg::HCRC_W-1:0] crc_acc_next;
  logic [gbnr_pkg::CRC_W-1:0]  crc_next;
  logic                        zero_seen_next;
  logic                        digits_ok_next;
  logic [gbnr_pkg::SEQ_W-1:0]  expected_next;

  logic                        is_digit;
  logic [gbnr_pkg::BYTE_W-1:0] digit_raw;
  logic [3:0]                  digit;
  logic [gbnr_pkg::SEQ_W-1:0]  cfg_sat;

  assign is_digit  = (item.rx_byte >= gbnr_pkg::CHAR_0) && (item.rx_byte <= gbnr_pkg::CHAR_9);
  assign digit_raw = item.rx_byte - gbnr_pkg::CHAR_0;
  assign digit     = digit_raw[3:0];
  assign cfg_sat   = (cfg_value > gbnr_pkg::SEQ_MAX) ? gbnr_pkg::SEQ_MAX : cfg_value;

  // Per-byte state update; bytes from position MAX_FRAME_BYTES-1 on are dropped
  always_comb begin
    pos_next       = pos;
    seq_acc_next   = seq_acc;
    ftype_next     = ftype;
    crc_acc_next   = crc_acc;
    crc_next       = crc;
    zero_seen_next = zero_seen;
    digits_ok_next = digits_ok;
    if (pos != POS_LAST) begin
      priority if (pos < POS_TYPE) begin
        if (is_digit) begin
          seq_acc_next = (seq_acc << 3) + (seq_acc << 1) + gbnr_pkg::SEQ_W'(digit);
        end else begin
          digits_ok_next = 1'b0;
        end
      end else if (pos == POS_TYPE) begin
        ftype_next = item.rx_byte;
      end else if (pos < POS_DATA) begin
        if (ftype == gbnr_pkg::CHAR_DATA) begin
          if (is_digit) begin
            crc_acc_next = (crc_acc << 3) + (crc_acc << 1) + gbnr_pkg::HCRC_W'(digit);
          end else begin
            digits_ok_next = 1'b0;
          end
        end
      end else if (!zero_seen) begin
        if (item.rx_byte == '0) begin
          zero_seen_next = 1'b1;
        end else begin
          crc_next = gbnr_pkg::crc_byte(crc, item.rx_byte);
        end
      end
      pos_next = pos + POS_W'(1);
    end
  end

  // Verdict from the state including this byte
  always_comb begin
    result         = '0;
    expected_next  = expected;
    result.verdict = gbnr_pkg::VERDICT_BAD_HEADER;
    if (ftype_next == gbnr_pkg::CHAR_ACK && pos_next >= POS_ACKOK && digits_ok_next) begin
      result.verdict        = gbnr_pkg::VERDICT_ACK;
      result.frame_sequence = seq_acc_next;
    end else if (ftype_next == gbnr_pkg::CHAR_DATA && pos_next >= POS_DATA
                 && digits_ok_next) begin
      result.frame_sequence = seq_acc_next;
      result.computed_crc   = crc_next;
      result.header_crc     = crc_acc_next;
      priority if (crc_acc_next != gbnr_pkg::HCRC_W'(crc_next)) begin
        result.verdict = gbnr_pkg::VERDICT_BAD_CRC;
      end else if (seq_acc_next == expected) begin
        result.verdict = gbnr_pkg::VERDICT_DELIVER;
        expected_next  = (expected == gbnr_pkg::SEQ_MAX) ? '0
                                                         : expected + gbnr_pkg::SEQ_W'(1);
      end else if (seq_acc_next < expected) begin
        result.verdict = gbnr_pkg::VERDICT_DUPLICATE;
      end else begin
        result.verdict = gbnr_pkg::VERDICT_OUT_OF_ORD;
      end
    end
    result.send_ack        = (result.verdict == gbnr_pkg::VERDICT_DELIVER) ||
                             (result.verdict == gbnr_pkg::VERDICT_DUPLICATE);
    result.deliver_payload = (result.verdict == gbnr_pkg::VERDICT_DELIVER);
    result.next_expected   = expected_next;
  end

  // State registers; a frame end or a register write starts a fresh frame
  always_ff @(posedge clk) begin
    if (rst || cfg_we || (step && item.frame_end)) begin
      pos       <= '0;
      seq_acc   <= '0;
      ftype     <= '0;
      crc_acc   <= '0;
      crc       <= '0;
      zero_seen <= 1'b0;
      digits_ok <= 1'b1;
    end else if (step) begin
      pos       <= pos_next;
      seq_acc   <= seq_acc_next;
      ftype     <= ftype_next;
      crc_acc   <= crc_acc_next;
      crc       <= crc_next;
      zero_seen <= zero_seen_next;
      digits_ok <= digits_ok_next;
    end
  end

  // Expected sequence number
  always_ff @(posedge clk) begin
    if (rst) begin
      expected <= gbnr_pkg::START_SEQ_RESET;
    end else if (cfg_we) begin
      expected <= cfg_sat;
    end else if (step && item.frame_end) begin
      expected <= expected_next;
    end
  end

endmodule

// File: rtl/gbnr_out_reg.sv
// ----------------------------------------------------------------------------
// gbnr_out_reg: verdict output register
// Holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module gbnr_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  gbnr_pkg::result_t result,
  output logic              out_free,
  gbnr_result_if.source     res
);

  gbnr_pkg::result_t held;

  assign out_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign res.verdict         = held.verdict;
  assign res.frame_sequence  = held.frame_sequence;
  assign res.send_ack        = held.send_ack;
  assign res.deliver_payload = held.deliver_payload;
  assign res.next_expected   = held.next_expected;
  assign res.computed_crc    = held.computed_crc;
  assign res.header_crc      = held.header_crc;

endmodule
